// File: rtl/core/cpfd_pkg.sv
// ----------------------------------------------------------------------------
// cpfd_pkg
// types, codes and helpers shared by the control pad frame decoder files
// ----------------------------------------------------------------------------
package cpfd_pkg;

	localparam int unsigned AXIS_W   = 7;
	localparam int unsigned POS_W    = 3;
	localparam int unsigned IN_W     = 8;
	localparam int unsigned REC_W    = 37;
	localparam int unsigned OUT_W    = 40;

	localparam logic [AXIS_W-1:0] AXIS_NEUTRAL = 7'd64;

	// frame position codes
	localparam logic [POS_W-1:0] POS_UNSYNC = 3'd0;
	localparam logic [POS_W-1:0] POS_BYTE1  = 3'd1;
	localparam logic [POS_W-1:0] POS_BYTE2  = 3'd2;
	localparam logic [POS_W-1:0] POS_BYTE3  = 3'd3;
	localparam logic [POS_W-1:0] POS_BYTE4  = 3'd4;
	localparam logic [POS_W-1:0] POS_DONE   = 3'd5;

	// bit in byte 4 that flips the camera select
	localparam int unsigned CAM_SWITCH_BIT = 6;

	typedef logic [1:0] dir_t;

	localparam dir_t DIR_STOP = 2'd0;
	localparam dir_t DIR_ONE  = 2'd1;
	localparam dir_t DIR_TWO  = 2'd2;

	// raw 2-bit direction codes on the wire
	localparam logic [1:0] CODE_ONE = 2'b10;
	localparam logic [1:0] CODE_TWO = 2'b11;

	typedef struct packed {
		logic [AXIS_W-1:0] forward;
		logic [AXIS_W-1:0] yaw;
		logic [AXIS_W-1:0] vertical;
		dir_t              turn;
		dir_t              grip;
		dir_t              thrust;
		logic              lights;
		logic              cam_sel;
		dir_t              pan;
		dir_t              tilt;
		logic              aux;
		logic [POS_W-1:0]  pos;
	} rec_t;

	function automatic dir_t decode_dir(input logic [1:0] code);
		dir_t d;
		case (code)
			CODE_ONE: d = DIR_ONE;
			CODE_TWO: d = DIR_TWO;
			default:  d = DIR_STOP;
		endcase
		return d;
	endfunction

	// neutral record with the given frame position
	function automatic rec_t neutral_rec(input logic [POS_W-1:0] pos);
		rec_t r;
		r.forward  = AXIS_NEUTRAL;
		r.yaw      = AXIS_NEUTRAL;
		r.vertical = AXIS_NEUTRAL;
		r.turn     = DIR_STOP;
		r.grip     = DIR_STOP;
		r.thrust   = DIR_STOP;
		r.lights   = 1'b0;
		r.cam_sel  = 1'b0;
		r.pan      = DIR_STOP;
		r.tilt     = DIR_STOP;
		r.aux      = 1'b0;
		r.pos      = pos;
		return r;
	endfunction

endpackage

// File: rtl/core/control_pad_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// control_pad_frame_decoder_core
// decodes remote-control frame bytes into a full control record per byte
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one received byte per item, bit 0 set marks a frame start
//   m_axis returns one item per input item: the whole control record after
//   that byte is applied, plus the frame position (0 unsynced, 5 complete)
//   path: an accepted byte goes through the input register, then the record
//   register that also holds the decoder state
//   throughput: one item per cycle while m_axis_tready is high, set by the
//   single decode stage between the input register and the record register
//   stall: while a result waits with m_axis_tready low the record holds, one
//   more byte can wait in the input register, then s_axis_tready drops
//   reset: arst_n clears both valid flags and puts the record at neutral
//   (axes 64, all else 0, unsynchronized)
// ----------------------------------------------------------------------------
module control_pad_frame_decoder_core
	import cpfd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // rx_byte[7:0]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// forward_axis[6:0], yaw_axis[13:7], vertical_axis[20:14], arm_turn[22:21],
	// arm_grip[24:23], side_thrust[26:25], lights_on[27], camera_select[28],
	// camera_pan[30:29], camera_tilt[32:31], aux_button[33],
	// frame_position[36:34], zero[39:37]
	output logic [OUT_W-1:0] m_axis_tdata
);

	logic            valid_s1;
	logic [IN_W-1:0] byte_s1;
	logic            out_valid_q;
	rec_t            rec_q;
	rec_t            rec_nxt;
	logic            accept;
	logic            advance;

	// input stage moves on when the record register is free or being drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// decoder state and result are the same register: the record changes
	// only when a new result is loaded
	cpfd_decode u_decode (
		.rx_byte (byte_s1),
		.cur     (rec_q),
		.nxt     (rec_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rec_q       <= neutral_rec(POS_UNSYNC);
		end else if (advance) begin
			out_valid_q <= 1'b1;
			rec_q       <= rec_nxt;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		{(OUT_W - REC_W){1'b0}},
		rec_q.pos,
		rec_q.aux,
		rec_q.tilt,
		rec_q.pan,
		rec_q.cam_sel,
		rec_q.lights,
		rec_q.thrust,
		rec_q.grip,
		rec_q.turn,
		rec_q.vertical,
		rec_q.yaw,
		rec_q.forward
	};

endmodule

// File: rtl/core/cpfd_decode.sv
// ----------------------------------------------------------------------------
// cpfd_decode
// next control record from the current record and one received byte
// ----------------------------------------------------------------------------
module cpfd_decode
	import cpfd_pkg::*;
(
	input  logic [IN_W-1:0] rx_byte,
	input  rec_t            cur,
	output rec_t            nxt
);

	always_comb begin
		nxt = cur;
		if (rx_byte[0]) begin
			// sync byte always starts a new frame
			nxt.forward = rx_byte[7:1];
			nxt.pos     = POS_BYTE1;
		end else begin
			unique case (cur.pos)
				POS_BYTE1: begin
					nxt.yaw = rx_byte[7:1];
					nxt.pos = POS_BYTE2;
				end
				POS_BYTE2: begin
					nxt.vertical = rx_byte[7:1];
					nxt.pos      = POS_BYTE3;
				end
				POS_BYTE3: begin
					nxt.turn   = decode_dir(rx_byte[7:6]);
					nxt.grip   = decode_dir(rx_byte[5:4]);
					nxt.thrust = decode_dir(rx_byte[3:2]);
					// lights would flip on bit 0, which is clear on this path
					nxt.pos    = POS_BYTE4;
				end
				POS_BYTE4: begin
					nxt.pan     = decode_dir(rx_byte[5:4]);
					nxt.tilt    = decode_dir(rx_byte[3:2]);
					nxt.cam_sel = cur.cam_sel ^ rx_byte[CAM_SWITCH_BIT];
					nxt.pos     = POS_DONE;
				end
				default: begin
					// unsynchronized or past frame end: back to neutral
					nxt = neutral_rec(cur.pos);
				end
			endcase
		end
	end

endmodule

// File: rtl/core/cpfd_checker.sv
// ----------------------------------------------------------------------------
// cpfd_checker
// port-level checks on the decoder result stream
// ----------------------------------------------------------------------------
module cpfd_checker
	import cpfd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
	else $error("stalled result changed");

	// frame position never goes past frame complete
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[36:34] != 3'd6 && m_axis_tdata[36:34] != 3'd7)
	else $error("frame position out of range");

	// lights and aux are never set
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[27] && !m_axis_tdata[33])
	else $error("lights or aux set");

	// unsynchronized result is fully neutral
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[36:34] == POS_UNSYNC
		|-> m_axis_tdata[33:0] == {13'd0, AXIS_NEUTRAL, AXIS_NEUTRAL, AXIS_NEUTRAL})
	else $error("unsynchronized result not neutral");

endmodule

bind control_pad_frame_decoder_core cpfd_checker u_cpfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: tb/control_pad_record_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control_pad_record_check
// watches both streams of the frame decoder, keeps its own copy of the
// frame state, predicts the control record for every accepted byte and
// compares each returned item with the oldest prediction, field by field
// ----------------------------------------------------------------------------
module control_pad_record_check
	import cpfd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [OUT_W-1:0] m_axis_tdata,
	output int               mismatches,
	output int               records_due
);

	rec_t             expected_records[$];
	rec_t             shadow;
	logic [POS_W-1:0] frame_idx;
	int               mismatch_count = 0;
	int               records_seen = 0;

	assign mismatches = mismatch_count;

	task automatic flag_mismatch(input string what);
		$display("%0t ns: record %0d: %s", $time, records_seen, what);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want) begin
			flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	// 2-bit direction code on the wire: 10 -> one, 11 -> two, else stop
	function automatic dir_t dir_of(input logic [1:0] code);
		if (code == CODE_ONE) begin
			return DIR_ONE;
		end else if (code == CODE_TWO) begin
			return DIR_TWO;
		end
		return DIR_STOP;
	endfunction

	// frame position is left alone here
	task automatic clear_controls();
		shadow.forward  = AXIS_NEUTRAL;
		shadow.yaw      = AXIS_NEUTRAL;
		shadow.vertical = AXIS_NEUTRAL;
		shadow.turn     = DIR_STOP;
		shadow.grip     = DIR_STOP;
		shadow.thrust   = DIR_STOP;
		shadow.lights   = 1'b0;
		shadow.cam_sel  = 1'b0;
		shadow.pan      = DIR_STOP;
		shadow.tilt     = DIR_STOP;
		shadow.aux      = 1'b0;
	endtask

	task automatic apply_rx_byte(input logic [7:0] rx);
		if (rx[0]) begin
			// a sync byte always restarts the frame, other fields keep their values
			shadow.forward = rx[7:1];
			frame_idx      = POS_BYTE1;
		end else begin
			case (frame_idx)
				POS_BYTE1: begin
					shadow.yaw = rx[7:1];
					frame_idx  = POS_BYTE2;
				end
				POS_BYTE2: begin
					shadow.vertical = rx[7:1];
					frame_idx       = POS_BYTE3;
				end
				// lights and aux would flip on bit 0, but that bit is clear here
				POS_BYTE3: begin
					shadow.turn   = dir_of(rx[7:6]);
					shadow.grip   = dir_of(rx[5:4]);
					shadow.thrust = dir_of(rx[3:2]);
					frame_idx     = POS_BYTE4;
				end
				POS_BYTE4: begin
					shadow.pan  = dir_of(rx[5:4]);
					shadow.tilt = dir_of(rx[3:2]);
					if (rx[CAM_SWITCH_BIT]) begin
						shadow.cam_sel = ~shadow.cam_sel;
					end
					frame_idx = POS_DONE;
				end
				// not synchronized yet, or past the end of the frame
				default: begin
					clear_controls();
				end
			endcase
		end
		shadow.pos = frame_idx;
		expected_records.push_back(shadow);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rec_t want;
		rec_t got;
		if (!arst_n) begin
			expected_records.delete();
			frame_idx = POS_UNSYNC;
			clear_controls();
			shadow.pos = POS_UNSYNC;
			records_due <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_rx_byte(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				records_seen++;
				if (expected_records.size() == 0) begin
					flag_mismatch("item with no record expected");
				end else begin
					want         = expected_records.pop_front();
					got.forward  = m_axis_tdata[6:0];
					got.yaw      = m_axis_tdata[13:7];
					got.vertical = m_axis_tdata[20:14];
					got.turn     = m_axis_tdata[22:21];
					got.grip     = m_axis_tdata[24:23];
					got.thrust   = m_axis_tdata[26:25];
					got.lights   = m_axis_tdata[27];
					got.cam_sel  = m_axis_tdata[28];
					got.pan      = m_axis_tdata[30:29];
					got.tilt     = m_axis_tdata[32:31];
					got.aux      = m_axis_tdata[33];
					got.pos      = m_axis_tdata[36:34];
					compare_field("forward_axis", got.forward, want.forward);
					compare_field("yaw_axis", got.yaw, want.yaw);
					compare_field("vertical_axis", got.vertical, want.vertical);
					compare_field("arm_turn", got.turn, want.turn);
					compare_field("arm_grip", got.grip, want.grip);
					compare_field("side_thrust", got.thrust, want.thrust);
					compare_field("lights_on", got.lights, want.lights);
					compare_field("camera_select", got.cam_sel, want.cam_sel);
					compare_field("camera_pan", got.pan, want.pan);
					compare_field("camera_tilt", got.tilt, want.tilt);
					compare_field("aux_button", got.aux, want.aux);
					compare_field("frame_position", got.pos, want.pos);
					compare_field("pad bits", m_axis_tdata[39:37], 0);
				end
			end
			records_due <= expected_records.size();
		end
	end

endmodule

// File: tb/control_pad_frame_decoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control_pad_frame_decoder_core_test
// feeds the frame decoder with hand-picked bytes and then with mostly
// well-formed random frames mixed with cut-short frames, trailing bytes and
// noise, under random idling on both streams; a record checker beside the
// block predicts and compares every item, this module gives the verdict
// ----------------------------------------------------------------------------
module control_pad_frame_decoder_core_test;
	import cpfd_pkg::*;

	localparam int RANDOM_ITEMS = 800;
	// cycles with no item moving on either side before the run is given up
	localparam int QUIET_LIMIT  = 2000;
	// two-stage pipeline, spare cycles to catch stray items
	localparam int DRAIN_CYCLES = 8;
	// window of items with no idling on either side
	localparam int STEADY_FROM  = 320;
	localparam int STEADY_TO    = 470;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;   // rx_byte[7:0]
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;   // forward, yaw, vertical, turn, grip, thrust,
	                                  // lights, cam select, pan, tilt, aux, position
	logic             no_idle;
	int               mismatches;
	int               records_due;
	int               quiet_cycles = 0;
	int               items_sent = 0;

	// hand-picked opening bytes, reset leaves the decoder unsynchronized
	logic [7:0] opening_bytes[$] = '{
		8'h00,  // unsynchronized, all bits clear
		8'hFE,  // unsynchronized, all upper bits set
		8'hFF,  // sync, forward at top of range
		8'h00,  // yaw at zero
		8'hFE,  // vertical at top of range
		8'hB8,  // arm: turn one, grip two, thrust one
		8'h78,  // camera: select flips, pan two, tilt one
		8'h02,  // past frame end, back to neutral
		8'hFC,  // still past frame end
		8'h01,  // sync, forward at zero
		8'h80,  // yaw at neutral
		8'h7E,  // vertical 63
		8'hFC,  // arm: every field code 11
		8'hFE,  // camera: codes 11, select flips, bit 7 set
		8'h41,  // sync with bit 6 set, no camera flip from byte 0
		8'h54,  // yaw
		8'h00,  // vertical
		8'h54,  // arm: code 01 everywhere decodes as stop
		8'h40,  // camera: stop, stop, select flips
		8'h81,  // sync
		8'h03,  // sync where yaw was due
		8'h10,  // yaw
		8'h20,  // vertical
		8'h03,  // sync where the arm byte was due, lights bit set
		8'h3C,  // yaw
		8'h20,  // vertical
		8'hC4   // arm: turn two, grip stop, thrust code 01 is stop
	};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	control_pad_frame_decoder_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	control_pad_record_check u_record_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.records_due   (records_due)
	);

	// result side: stalls at random about 36 percent of the time, none in the steady window
	always @(posedge clk) begin
		m_axis_tready <= no_idle || ($urandom_range(99) >= 36);
	end

	// give up when nothing has moved on either stream for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("control_pad_frame_decoder_core_test: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offers one byte, with a random gap before it, and returns at the edge
	// where it is taken
	task automatic send_byte(input logic [7:0] rx);
		while (!no_idle && $urandom_range(99) < 36) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= rx;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	// random byte, bit 0 forced to the sync flag
	task automatic send_frame_byte(input logic sync);
		logic [7:0] rx;
		rx    = 8'($urandom);
		rx[0] = sync;
		no_idle <= (items_sent >= STEADY_FROM) && (items_sent < STEADY_TO);
		send_byte(rx);
	endtask

	initial begin
		int kind;
		int len;
		int total;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		no_idle       <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_bytes[i]) begin
			send_byte(opening_bytes[i]);
		end

		total = opening_bytes.size() + RANDOM_ITEMS;
		while (items_sent < total) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				// full frame, now and then followed by bytes past its end
				send_frame_byte(1'b1);
				repeat (4) send_frame_byte(1'b0);
				if ($urandom_range(99) < 20) begin
					len = $urandom_range(2, 1);
					repeat (len) send_frame_byte(1'b0);
				end
			end else if (kind < 85) begin
				// frame cut short, the next sync restarts it
				send_frame_byte(1'b1);
				len = $urandom_range(3, 0);
				repeat (len) send_frame_byte(1'b0);
			end else begin
				// noise: bit 0 as random as the rest
				len = $urandom_range(4, 1);
				repeat (len) send_frame_byte(1'($urandom_range(1)));
			end
		end
		s_axis_tvalid <= 1'b0;

		// the due count is registered, so wait for an edge before looking at it
		@(posedge clk);
		while (records_due != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("control_pad_frame_decoder_core_test: clean");
		end else begin
			$display("control_pad_frame_decoder_core_test: errors");
		end
		$finish;
	end

endmodule

// File: control_pad_frame_decoder_core.f
rtl/core/cpfd_pkg.sv
rtl/core/cpfd_decode.sv
rtl/core/control_pad_frame_decoder_core.sv
rtl/core/cpfd_checker.sv
tb/control_pad_record_check.sv
tb/control_pad_frame_decoder_core_test.sv
